>>> rtl/ssdr_pkg.sv
// Package for the SHiP/DRRIP replacement unit: request codes, stored-row types.
// No dependencies.
`default_nettype none
package ssdr_pkg;
  localparam int PaddrBits = 48;
  localparam int PcBits = 48;
  localparam int BlkShift = 6;
  localparam logic [15:0] LfsrSeed = 16'hACE1;
  localparam logic [9:0] DuelInit = 10'd512;
  localparam logic [9:0] DuelMax = 10'd1023;
  localparam logic [1:0] RrpvDistant = 2'd3;
  localparam logic [1:0] RrpvLong = 2'd2;
  localparam logic [1:0] RrpvNear = 2'd0;

  typedef enum logic {FUNC_VICTIM = 1'b0, FUNC_UPDATE = 1'b1} func_t;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_EXEC, ST_WRITE, ST_OUT
  } state_t;

  typedef struct packed {
    logic [7:0] last_blk;
    logic [7:0] last_delta;
    logic [1:0] level;
  } stream_t;
endpackage
`default_nettype wire

>>> rtl/ssdr_stream_if.sv
// Valid/ready channel interface with a generic payload.
// Depends on nothing.
`default_nettype none
interface ssdr_stream_if #(parameter type payload_t = logic) (input wire logic clk);
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/ssdr_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module ssdr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input wire logic clk,
  input wire logic we,
  input wire logic [$clog2(DEPTH)-1:0] waddr,
  input wire logic [WIDTH-1:0] wdata,
  input wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> rtl/ship_stream_drrip_replacement_unit.sv
// Top level of the SHiP-lite DRRIP replacement unit with stream bypass.
// Depends on ssdr_pkg, ssdr_stream_if and ssdr_ram.
//
// Use: requests arrive on req (func, set_index, way, paddr, pc, hit); each
// produces exactly one response on rsp (victim_way, bypassed).
// A victim request (func 0) ages the set and returns the lowest way at 3.
// An update (func 1) trains the stride detector, then on a hit trains the
// outcome table and promotes the way; on a fill it inserts or bypasses.
// Each request is a read-modify-write of one set row held in memory: the
// reads are issued in READ, the row is computed in EXEC and written back in
// WRITE, then the response is presented in OUT.
// The response register holds its value while rsp.ready is low and the
// next request is taken only after the response transfer.
// After reset a clearing pass writes every set row and every outcome counter,
// one entry per cycle; req.ready stays low during it. The duel selector and
// the LFSR live in flip-flops.
`default_nettype none
module ship_stream_drrip_replacement_unit #(
  parameter int SETS = 2048,
  parameter int WAYS = 16,
  parameter int SIG_BITS = 6,
  parameter int LEADER_SETS = 32
) (
  input wire logic clk,
  input wire logic rst,
  ssdr_stream_if.sink req,
  ssdr_stream_if.source rsp
);
  import ssdr_pkg::*;

  localparam int SetW = $clog2(SETS);
  localparam int WayW = $clog2(WAYS);
  localparam int SigN = 1 << SIG_BITS;
  localparam int RowW = WAYS * (2 + SIG_BITS);
  localparam int ClrN = (SETS > SigN) ? SETS : SigN;
  localparam int ClrW = $clog2(ClrN);

  state_t state, state_next;
  logic [ClrW-1:0] clr_cnt;
  logic f_upd, f_hit;
  logic [SetW-1:0] f_set;
  logic [WayW-1:0] f_way;
  logic [PaddrBits-BlkShift-1:0] f_blk;
  logic [SIG_BITS-1:0] f_sig;
  logic [9:0] duel;
  logic [15:0] lfsr;
  logic [3:0] o_way;
  logic o_byp;

  // Row memory: per way an RRPV and a signature.
  logic row_we;
  logic [SetW-1:0] row_waddr;
  logic [RowW-1:0] row_wdata, row_rdata;
  logic st_we;
  stream_t st_wdata, st_rdata;

  // Outcome table memory and its training registers.
  logic otab_we;
  logic [SIG_BITS-1:0] otab_waddr, otab_raddr;
  logic [1:0] otab_wdata, otab_rdata;
  logic [SIG_BITS-1:0] train_sig;
  logic otab_dec;

  ssdr_ram #(.WIDTH(RowW), .DEPTH(SETS)) u_row (
    .clk, .we(row_we), .waddr(row_waddr), .wdata(row_wdata),
    .raddr(f_set), .rdata(row_rdata));
  ssdr_ram #(.WIDTH($bits(stream_t)), .DEPTH(SETS)) u_stream (
    .clk, .we(st_we), .waddr(row_waddr), .wdata(st_wdata),
    .raddr(f_set), .rdata(st_rdata));
  ssdr_ram #(.WIDTH(2), .DEPTH(SigN)) u_otab (
    .clk, .we(otab_we), .waddr(otab_waddr), .wdata(otab_wdata),
    .raddr(otab_raddr), .rdata(otab_rdata));

  assign req.ready = (state == ST_IDLE);
  assign rsp.valid = (state == ST_OUT);
  assign rsp.data.victim_way = o_way;
  assign rsp.data.bypassed = o_byp;

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_cnt == ClrW'(ClrN - 1)) state_next = ST_IDLE;
      ST_IDLE: if (req.valid) state_next = ST_READ;
      ST_READ: state_next = ST_EXEC;
      ST_EXEC: state_next = ST_WRITE;
      ST_WRITE: state_next = ST_OUT;
      ST_OUT: if (rsp.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Compute on the read row, registered inputs.
  logic [1:0] rr [WAYS];
  logic [SIG_BITS-1:0] sg [WAYS];
  logic [1:0] mx;
  logic [WayW:0] vic;
  logic [7:0] delta;
  logic [1:0] lvl;
  logic srl, brl, use_s, bypass;
  logic [15:0] d1, d2, lf_fin;
  logic [1:0] ins;
  logic [SIG_BITS-1:0] old_sig;
  logic [RowW-1:0] row_new;

  function automatic logic [15:0] step(input logic [15:0] v);
    return {v[0] ^ v[2] ^ v[3] ^ v[5], v[15:1]};
  endfunction

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      rr[i] = row_rdata[i*(2+SIG_BITS) +: 2];
      sg[i] = row_rdata[i*(2+SIG_BITS)+2 +: SIG_BITS];
    end
    mx = 2'd0;
    for (int i = 0; i < WAYS; i++) mx = mx | rr[i];
    // max of 2-bit values: OR gives the highest set bit; refine low bit.
    if (mx[1]) begin
      mx[0] = 1'b0;
      for (int i = 0; i < WAYS; i++) if (rr[i] == 2'd3) mx[0] = 1'b1;
    end
    vic = (WayW+1)'(WAYS);
    for (int i = WAYS - 1; i >= 0; i--)
      if (2'(rr[i] + (RrpvDistant - mx)) == RrpvDistant) vic = (WayW+1)'(i);
    delta = 8'(f_blk) - st_rdata.last_blk;
    lvl = st_rdata.level;
    if (delta == st_rdata.last_delta && delta != 8'd0) begin
      if (lvl != 2'd3) lvl = lvl + 2'd1;
    end else if (lvl != 2'd0) lvl = lvl - 2'd1;
    srl = (32'(f_set) < 32'(LEADER_SETS));
    brl = !srl && (33'(f_set) + 33'(LEADER_SETS) >= 33'(SETS));
    use_s = srl || (!brl && duel >= DuelInit);
    d1 = use_s ? lfsr : step(lfsr);
    ins = (!use_s && d1[4:0] == 5'd0) ? RrpvDistant : RrpvLong;
    if (otab_rdata >= 2'd2) ins = RrpvNear;
    d2 = step(d1);
    bypass = 1'b0;
    lf_fin = d1;
    if (lvl >= 2'd2) begin
      lf_fin = d2;
      if (!d2[0]) bypass = 1'b1;
      ins = RrpvDistant;
    end
    old_sig = sg[f_way];
    row_new = row_rdata;
    if (!f_upd) begin
      for (int i = 0; i < WAYS; i++)
        row_new[i*(2+SIG_BITS) +: 2] = 2'(rr[i] + (RrpvDistant - mx));
    end else begin
      row_new[32'(f_way)*(2+SIG_BITS) +: 2] = f_hit ? RrpvNear : ins;
      row_new[32'(f_way)*(2+SIG_BITS)+2 +: SIG_BITS] = f_sig;
    end
  end

  // The counter of the new signature is read with the row; a fill then reads
  // the counter of the signature it replaces while the row is computed.
  assign otab_raddr = (state == ST_EXEC && !f_hit) ? old_sig : f_sig;

  logic [RowW-1:0] row_hold;
  stream_t st_hold;
  logic hold_we;

  always_comb begin
    row_we = 1'b0;
    st_we = 1'b0;
    otab_we = 1'b0;
    row_waddr = f_set;
    row_wdata = row_hold;
    st_wdata = st_hold;
    otab_waddr = train_sig;
    otab_wdata = f_hit ? otab_rdata + 2'd1 : otab_rdata - 2'd1;
    case (state)
      ST_CLEAR: begin
        row_we = 1'b1;
        st_we = 1'b1;
        otab_we = 1'b1;
        row_waddr = SetW'(clr_cnt);
        for (int i = 0; i < WAYS; i++)
          row_wdata[i*(2+SIG_BITS) +: 2+SIG_BITS] = {{SIG_BITS{1'b0}}, RrpvDistant};
        st_wdata = '0;
        otab_waddr = SIG_BITS'(clr_cnt);
        otab_wdata = 2'd0;
      end
      ST_WRITE: begin
        row_we = hold_we;
        st_we = f_upd;
        otab_we = f_upd && (f_hit ? (otab_rdata != 2'd3)
                                  : (otab_dec && otab_rdata != 2'd0));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_cnt <= '0;
      duel <= DuelInit;
      lfsr <= LfsrSeed;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + ClrW'(1);
      if (state == ST_EXEC && f_upd) begin
        if (f_hit) begin
          if (srl) begin
            if (duel != DuelMax) duel <= duel + 10'd1;
          end else if (brl && duel != 10'd0) duel <= duel - 10'd1;
        end else begin
          lfsr <= lf_fin;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req.valid) begin
      f_upd <= (req.data.func == FUNC_UPDATE);
      f_hit <= req.data.hit;
      f_set <= SetW'(32'(req.data.set_index) % SETS);
      f_way <= WayW'(32'(req.data.way) % WAYS);
      f_blk <= req.data.paddr[PaddrBits-1:BlkShift];
      f_sig <= SIG_BITS'(req.data.pc ^ PcBits'(req.data.paddr[PaddrBits-1:BlkShift]));
    end
    if (state == ST_EXEC) begin
      row_hold <= row_new;
      st_hold <= '{last_blk: 8'(f_blk), last_delta: delta, level: lvl};
      hold_we <= !(f_upd && !f_hit && bypass);
      o_way <= f_upd ? 4'd0 : 4'(vic);
      o_byp <= f_upd && !f_hit && bypass;
      train_sig <= f_hit ? f_sig : old_sig;
      otab_dec <= !bypass && ins == RrpvDistant;
    end
  end
endmodule
`default_nettype wire

>>> rtl/ssdr_checker.sv
// Port-level assertions for the replacement unit, bound to the top level.
// Depends on ssdr_stream_if through the bound top level's ports.
`default_nettype none
module ssdr_props (
  input wire logic clk,
  input wire logic rst,
  input wire logic req_valid,
  input wire logic req_ready,
  input wire logic rsp_valid,
  input wire logic rsp_ready,
  input wire logic [3:0] victim_way,
  input wire logic bypassed
);
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(req_ready && rsp_valid)) else $error("request taken while response pending");
  a_resp_latency: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |-> ##4 rsp_valid) else $error("response not on time");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(victim_way) && $stable(bypassed))
    else $error("stalled response changed");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && bypassed |-> victim_way == 4'd0) else $error("bypass with victim way");
endmodule

bind ship_stream_drrip_replacement_unit ssdr_props u_ssdr_props (
  .clk(clk), .rst(rst), .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .victim_way(rsp.data.victim_way), .bypassed(rsp.data.bypassed));
`default_nettype wire

>>> verif/ssdr_tb_pkg.sv
// Request and response payload types for the replacement unit's channels.
// Depends on ssdr_pkg for the request code type.
package ssdr_tb_pkg;
  import ssdr_pkg::*;

  typedef struct packed {
    func_t       func;
    logic [10:0] set_index;
    logic [3:0]  way;
    logic [47:0] paddr;
    logic [47:0] pc;
    logic        hit;
  } req_t;

  typedef struct packed {
    logic [3:0] victim_way;
    logic       bypassed;
  } rsp_t;
endpackage

>>> verif/ssdr_checker.sv
// Checker for the replacement unit: mirrors the policy state, predicts each
// response from the accepted requests and compares it. Depends on ssdr_pkg, ssdr_tb_pkg.
module ssdr_checker
  import ssdr_pkg::*;
  import ssdr_tb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  input  wire logic req_ready,
  input  req_t      req_data,
  input  wire logic rsp_valid,
  input  wire logic rsp_ready,
  input  rsp_t      rsp_data,
  output int        fail_count,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSets = 2048;
  localparam int NWays = 16;
  localparam int Leaders = 32;

  logic [1:0]  rrpv [NSets][NWays];
  logic [5:0]  sig_of [NSets][NWays];
  logic [1:0]  reuse_ctr [64];
  logic [7:0]  prev_blk [NSets];
  logic [7:0]  delta_hist [NSets];
  logic [1:0]  stream_lvl [NSets];
  logic [9:0]  psel;
  logic [15:0] lfsr;
  rsp_t        awaited [$];

  assign pending = awaited.size();

  function automatic logic [15:0] next_rand();
    logic b;
    b = lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5];
    lfsr = {b, lfsr[15:1]};
    return lfsr;
  endfunction

  function automatic rsp_t replace_decision(req_t r);
    rsp_t        o;
    int          s, w;
    logic [1:0]  mx, ins;
    logic [41:0] blk;
    logic [5:0]  sig, old_sig;
    logic [7:0]  delta;
    logic        srrip;
    o = '0;
    s = r.set_index;
    w = r.way;
    if (r.func == FUNC_VICTIM) begin
      mx = 0;
      for (int i = 0; i < NWays; i++) if (rrpv[s][i] > mx) mx = rrpv[s][i];
      for (int i = 0; i < NWays; i++) rrpv[s][i] = rrpv[s][i] + (RrpvDistant - mx);
      for (int i = NWays - 1; i >= 0; i--) if (rrpv[s][i] == RrpvDistant) o.victim_way = i;
      return o;
    end
    blk = r.paddr[47:6];
    sig = r.pc[5:0] ^ blk[5:0];
    delta = blk[7:0] - prev_blk[s];
    if (delta == delta_hist[s] && delta != 0) begin
      if (stream_lvl[s] < 3) stream_lvl[s]++;
    end else if (stream_lvl[s] > 0) begin
      stream_lvl[s]--;
    end
    prev_blk[s] = blk[7:0];
    delta_hist[s] = delta;
    if (r.hit) begin
      sig_of[s][w] = sig;
      if (reuse_ctr[sig] < 3) reuse_ctr[sig]++;
      rrpv[s][w] = RrpvNear;
      if (s < Leaders) begin
        if (psel < DuelMax) psel++;
      end else if (s >= NSets - Leaders) begin
        if (psel > 0) psel--;
      end
      return o;
    end
    if (s < Leaders) srrip = 1;
    else if (s >= NSets - Leaders) srrip = 0;
    else srrip = psel >= DuelInit;
    ins = RrpvLong;
    if (!srrip) ins = (next_rand() & 16'h1f) == 0 ? RrpvDistant : RrpvLong;
    if (reuse_ctr[sig] >= 2) ins = RrpvNear;
    if (stream_lvl[s] >= 2) begin
      if (next_rand() & 16'h1) ins = RrpvDistant;
      else begin
        o.bypassed = 1;
        return o;
      end
    end
    old_sig = sig_of[s][w];
    rrpv[s][w] = ins;
    sig_of[s][w] = sig;
    if (ins == RrpvDistant && reuse_ctr[old_sig] > 0) reuse_ctr[old_sig]--;
    return o;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NSets; i++) begin
        for (int j = 0; j < NWays; j++) begin
          rrpv[i][j] = RrpvDistant;
          sig_of[i][j] = 0;
        end
        prev_blk[i] = 0;
        delta_hist[i] = 0;
        stream_lvl[i] = 0;
      end
      for (int i = 0; i < 64; i++) reuse_ctr[i] = 0;
      psel = DuelInit;
      lfsr = LfsrSeed;
      fail_count = 0;
      awaited.delete();
    end else begin
      // Check the response before predicting the new transfer, should a response
      // and a new request ever transfer in the same cycle.
      if (rsp_valid && rsp_ready) begin
        if (awaited.size() == 0) begin
          $error("response with no request outstanding");
          fail_count++;
        end else begin
          rsp_t e;
          e = awaited.pop_front();
          if (e.victim_way !== rsp_data.victim_way) begin
            $error("victim_way: expected %0d, got %0d", e.victim_way, rsp_data.victim_way);
            fail_count++;
          end
          if (e.bypassed !== rsp_data.bypassed) begin
            $error("bypassed: expected %0d, got %0d", e.bypassed, rsp_data.bypassed);
            fail_count++;
          end
        end
      end
      if (req_valid && req_ready) awaited.push_back(replace_decision(req_data));
    end
  end
endmodule

>>> verif/testbench.sv
// Top of the replacement unit testbench: clock, reset, request stimulus,
// response stalls and the verdict. Depends on ssdr_pkg, ssdr_tb_pkg, ssdr_checker.
module testbench;
  import ssdr_pkg::*;
  import ssdr_tb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumItems = 1600;
  localparam int StallLimit = 5000;

  logic clk = 0;
  logic rst = 1;
  logic calm = 0;
  logic long_hold = 0;
  int   fail_count, pending, quiet_cycles;

  ssdr_stream_if #(.payload_t(req_t)) req_if (clk);
  ssdr_stream_if #(.payload_t(rsp_t)) rsp_if (clk);

  ship_stream_drrip_replacement_unit i_dut (.clk(clk), .rst(rst), .req(req_if), .rsp(rsp_if));

  ssdr_checker i_checker (
    .clk(clk), .rst(rst),
    .req_valid(req_if.valid), .req_ready(req_if.ready), .req_data(req_if.data),
    .rsp_valid(rsp_if.valid), .rsp_ready(rsp_if.ready), .rsp_data(rsp_if.data),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Response side: random stall bursts, one long hold-off on request, none at the end.
  initial begin
    logic hold_done;
    hold_done = 0;
    rsp_if.ready <= 0;
    wait (!rst);
    forever begin
      if (long_hold && !hold_done) begin
        rsp_if.ready <= 0;
        repeat (300) @(posedge clk);
        hold_done = 1;
      end else if (calm) begin
        rsp_if.ready <= 1;
        @(posedge clk);
      end else begin
        rsp_if.ready <= $urandom_range(0, 2) != 0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  task automatic send_req(req_t it);
    req_if.valid <= 1;
    req_if.data <= it;
    do @(posedge clk); while (!req_if.ready);
  endtask

  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()});
  endfunction

  function automatic req_t make_req(func_t f, int s, int w, logic [47:0] pa, logic [47:0] p,
                                    logic h);
    req_t r;
    r.func = f;
    r.set_index = 11'(s);
    r.way = 4'(w);
    r.paddr = pa;
    r.pc = p;
    r.hit = h;
    return r;
  endfunction

  function automatic int pick_set();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 31);
      1: return $urandom_range(2016, 2047);
      2: return 100 + $urandom_range(0, 15);
      default: return $urandom_range(0, 2047);
    endcase
  endfunction

  initial begin
    req_t        dir [$];
    req_t        r;
    int          sent, s, len, stride;
    logic [47:0] base, pcs [8];
    req_if.valid <= 0;
    req_if.data <= '0;
    repeat (6) @(posedge clk);
    rst <= 0;
    for (int i = 0; i < 8; i++) pcs[i] = rand48();

    // Directed: extremes, both functions, leader and follower sets, a stream.
    dir.push_back(make_req(FUNC_VICTIM, 0, 0, 0, 0, 0));
    dir.push_back(make_req(FUNC_VICTIM, 2047, 15, '1, '1, 1));
    dir.push_back(make_req(FUNC_UPDATE, 0, 15, '1, '1, 0));
    dir.push_back(make_req(FUNC_UPDATE, 0, 15, '1, '1, 1));
    dir.push_back(make_req(FUNC_UPDATE, 0, 3, '1, '1, 1));
    dir.push_back(make_req(FUNC_UPDATE, 2047, 0, 0, 0, 1));
    dir.push_back(make_req(FUNC_UPDATE, 2047, 1, 48'h40, 0, 0));
    dir.push_back(make_req(FUNC_UPDATE, 500, 2, 48'h80, 48'h5, 0));
    dir.push_back(make_req(FUNC_VICTIM, 0, 0, 0, 0, 0));
    dir.push_back(make_req(FUNC_VICTIM, 2047, 0, 0, 0, 0));
    for (int i = 1; i <= 6; i++)
      dir.push_back(make_req(FUNC_UPDATE, 700, i, 48'h1000 + i * 64 * 3, 48'h77, 0));
    dir.push_back(make_req(FUNC_VICTIM, 700, 0, 0, 0, 0));
    dir.push_back(make_req(FUNC_UPDATE, 700, 0, 48'hfff0_0000_0000, 48'h0, 1));
    sent = 0;
    foreach (dir[i]) begin
      send_req(dir[i]);
      sent++;
    end

    while (sent < NumItems) begin
      if (sent > NumItems - 200) calm = 1;
      if (sent >= 400 && sent < 400 + 20 && !long_hold && sent % 20 == 0) long_hold = 1;
      if (sent >= 800 && sent < 810) begin
        // Pause until every outstanding response has been seen.
        req_if.valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      s = pick_set();
      if ($urandom_range(0, 3) == 0) begin
        // Noise: any request at all.
        r = make_req(func_t'($urandom_range(0, 1)), $urandom_range(0, 2047),
                     $urandom_range(0, 15), rand48(), rand48(), 1'($urandom_range(0, 1)));
        len = 1;
      end else begin
        len = $urandom_range(3, 10);
        stride = $urandom_range(0, 5) == 0 ? $urandom_range(0, 255) : $urandom_range(1, 4);
        base = rand48();
      end
      for (int k = 0; k < len && sent < NumItems; k++) begin
        if (len > 1) begin
          if ($urandom_range(0, 3) == 0) begin
            r = make_req(FUNC_VICTIM, s, $urandom_range(0, 15), rand48(), rand48(), 0);
          end else begin
            base = base + (48'(stride) << 6);
            r = make_req(FUNC_UPDATE, s, $urandom_range(0, 15), base,
                         pcs[$urandom_range(0, 7)], $urandom_range(0, 2) == 0);
          end
        end
        if (!calm && $urandom_range(0, 4) == 0) begin
          req_if.valid <= 0;
          repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        send_req(r);
        sent++;
      end
    end
    req_if.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
